### src/sbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by sbs_table and sorted_table_binary_search; depends on nothing.
package sbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned COUNT_W         = 7;
  localparam int unsigned INDEX_W         = 6;
  localparam int unsigned WORD_W          = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [WORD_W-1:0]  entry_value;
    logic signed [WORD_W-1:0]  search_key;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } res_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINAL
  } state_e;

endpackage

### src/sbs_table.sv
// Entry table: one synchronous memory with one write port and one read port.
// Read data is registered and valid in the cycle after the read enable; uses sbs_pkg.
module sbs_table #(
  parameter int unsigned DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [sbs_pkg::WORD_W-1:0]   wr_data_i,
  input  logic                                rd_en_i,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [sbs_pkg::WORD_W-1:0]   rd_data_o
);

  logic signed [sbs_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic signed [sbs_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/sorted_table_binary_search.sv
// Binary search over a sorted table of signed words. A write gives no result.
// A search halves [lo, hi) once per cycle, one table read per probe, with P
// probes (P <= clog2 of the entry count, 6 for 64 entries); busy stays high
// through ST_PROBE and ST_FINAL, and done_o, registered from ST_FINAL, then
// pulses. Reset clears the control state and entry_count; the table contents
// stay undefined until written. The result cannot be stalled.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sbs_pkg::COUNT_W-1:0]  cfg_data_i,
  input  logic                         start,
  output logic                         busy,
  input  sbs_pkg::in_item_t            in_i,
  output logic                         done_o,
  output sbs_pkg::res_item_t           res_o
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW    = sbs_pkg::COUNT_W;
  localparam int unsigned MAX_N = (TABLE_DEPTH > (2**CW - 1)) ? (2**CW - 1) : TABLE_DEPTH;

  sbs_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q;
  logic [CW-1:0] n_sat;
  logic [CW-1:0] lo_q, hi_q, m_q;
  logic [CW-1:0] lo_n, hi_n, m_n, span_n;
  logic          more_n;
  logic          nz_q;
  logic signed [sbs_pkg::WORD_W-1:0] key_q;
  logic signed [sbs_pkg::WORD_W-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          take;
  logic          search_go;
  logic          hit;
  logic          done_q;
  sbs_pkg::res_item_t res_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != sbs_pkg::ST_IDLE);
  assign take        = start && !busy;
  assign search_go   = take && (in_i.mode == sbs_pkg::MODE_SEARCH);
  // Writes beyond the table are dropped.
  assign wr_en       = take && (in_i.mode == sbs_pkg::MODE_WRITE) &&
                       (32'(in_i.entry_index) < 32'(TABLE_DEPTH));
  assign n_sat       = (count_q > CW'(MAX_N)) ? CW'(MAX_N) : count_q;

  sbs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(in_i.entry_index)),
    .wr_data_i (in_i.entry_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The bounds after this cycle's decision pick the next read address at once.
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        lo_n = '0;
        hi_n = n_sat;
      end
      sbs_pkg::ST_PROBE: begin
        if (key_q < rd_data) begin
          hi_n = m_q;
        end else begin
          lo_n = m_q;
        end
      end
      default: begin
        lo_n = lo_q;
        hi_n = hi_q;
      end
    endcase
    span_n  = hi_n - lo_n;
    more_n  = (span_n > CW'(1));
    m_n     = lo_n + (span_n >> 1);
    rd_addr = more_n ? AW'(m_n) : AW'(lo_n);
    rd_en   = search_go || (state_q == sbs_pkg::ST_PROBE);
    hit     = nz_q && (rd_data == key_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        if (search_go) begin
          state_d = more_n ? sbs_pkg::ST_PROBE : sbs_pkg::ST_FINAL;
        end
      end
      sbs_pkg::ST_PROBE: begin
        state_d = more_n ? sbs_pkg::ST_PROBE : sbs_pkg::ST_FINAL;
      end
      sbs_pkg::ST_FINAL: begin
        state_d = sbs_pkg::ST_IDLE;
      end
      default: begin
        state_d = sbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbs_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == sbs_pkg::ST_FINAL);
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
      m_q  <= m_n;
    end
    if (search_go) begin
      key_q <= in_i.search_key;
      nz_q  <= (n_sat != '0);
    end
    if (state_q == sbs_pkg::ST_FINAL) begin
      res_q.found    <= hit;
      res_q.position <= hit ? sbs_pkg::INDEX_W'(lo_q) : '0;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == sbs_pkg::ST_FINAL)
    else $error("result strobe without a final compare");

  a_miss_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.position == '0))
    else $error("position not zero on a miss");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbs_pkg::ST_PROBE) |-> (lo_q < m_q) && (m_q < hi_q))
    else $error("probe index outside the search window");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    search_go |=> busy)
    else $error("search accepted but block not busy");

endmodule
